// ===== design/sv39pm_pkg.sv =====
// Shared constants, widths and helpers of the Sv39 page mapping engine.
package sv39pm_pkg;

  localparam int TABLE_PAGES       = 64;
  localparam int ENTRIES_PER_TABLE = 512;

  localparam int VPN_W   = 27;
  localparam int PPN_W   = 44;
  localparam int PERM_W  = 10;
  localparam int ENTRY_W = PPN_W + PERM_W;
  localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W  = $clog2(TABLE_PAGES);
  localparam int NF_W    = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W  = PAGE_W + IDX_W;
  localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // Store address of one entry: table page in the upper bits, index below.
  function automatic logic [ADDR_W-1:0] slot(input logic [PAGE_W-1:0] page,
                                             input logic [IDX_W-1:0]  idx);
    slot = {page, idx};
  endfunction

  // Pointer entry to a table page: its PPN with only V set.
  function automatic logic [ENTRY_W-1:0] pointer_entry(input logic [PPN_W-1:0] ppn);
    pointer_entry = {ppn, {(PERM_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

// ===== design/sv39pm_in_if.sv =====
// Request channel of the Sv39 page mapping engine: one page to map per word.
interface sv39pm_in_if;
  import sv39pm_pkg::*;

  logic              valid;
  logic              ready;
  logic [VPN_W-1:0]  virt_page_number;
  logic [PPN_W-1:0]  phys_page_number;
  logic [PERM_W-1:0] perm;
  logic              last_page;

  modport source (output valid, virt_page_number, phys_page_number, perm, last_page,
                  input ready);
  modport sink (input valid, virt_page_number, phys_page_number, perm, last_page,
                output ready);
endinterface

// ===== design/sv39pm_out_if.sv =====
// Result channel of the Sv39 page mapping engine: one result word per page.
interface sv39pm_out_if;
  import sv39pm_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [ENTRY_W-1:0] leaf_entry;
  logic [1:0]         tables_added;
  logic               request_done;

  modport source (output valid, status, leaf_entry, tables_added, request_done,
                  input ready);
  modport sink (input valid, status, leaf_entry, tables_added, request_done,
                output ready);
endinterface

// ===== design/sv39pm_table_ram.sv =====
// Single-port table store with a registered read port.
module sv39pm_table_ram #(
  parameter int DEPTH  = 32768,
  parameter int DATA_W = 54
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write or read, one access a cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/sv39_page_mapping_engine_unit.sv =====
// Top level of the Sv39 page mapping engine: walk sequencer around the table store.
//
// Each request word maps one 4 KiB page into a three-level Sv39 page table held
// in an on-chip store of TABLE_PAGES table pages of 512 entries; page zero is the
// root and its PPN is table_base_ppn. The engine reads the level-2 entry, then
// (if it is valid) the level-1 entry, takes fresh table pages from a bump pool
// where an entry is not valid, writes the missing pointer entries and finally the
// leaf entry. The result word is loaded in S_OUT, after S_RD2, then S_RD1 when the
// level-2 entry is valid, then those of S_W2, S_W1 and S_W0 that the walk needs
// (a refused page goes from a read straight to S_OUT): every read and write goes
// through the single port of the store, and each read depends on the one before
// it. The engine is back in idle as the result is loaded. One page is in flight
// at a time; the result register lets the next page be accepted while a result
// still waits to be taken. If the pool cannot supply the pages needed, or a
// pointer names a page outside the store under the current table_base_ppn, the
// result has status 1 and nothing is written. After reset the engine zeroes the
// whole store, all STORE_DEPTH (32768) entries, one entry a cycle, with ready held
// low; requests are taken once the pass is done. Write table_base_ppn only while
// no page is in flight.
module sv39_page_mapping_engine_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [sv39pm_pkg::PPN_W-1:0] cfg_wr_data,
  sv39pm_in_if.sink                 req,
  sv39pm_out_if.source              rsp
);
  import sv39pm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD2   = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_W2    = 3'd3;
  localparam logic [2:0] S_W1    = 3'd4;
  localparam logic [2:0] S_W0    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  // Control state.
  logic [2:0]        state, state_next;
  logic [NF_W-1:0]   next_free, next_free_next;
  logic              out_valid;
  logic [ADDR_W-1:0] clr_addr;

  // Working registers of the page in flight.
  logic [PPN_W-1:0]  table_base_ppn;
  logic [VPN_W-1:0]  vpn;
  logic [PPN_W-1:0]  ppn;
  logic [PERM_W-1:0] perm;
  logic              last;
  logic [PAGE_W-1:0] l1_page, l1_page_next;
  logic [PAGE_W-1:0] l0_page, l0_page_next;
  logic [1:0]        need, need_next;
  logic              err, err_next;

  // Result register.
  logic               out_status;
  logic [ENTRY_W-1:0] out_leaf;
  logic [1:0]         out_added;
  logic               out_done;

  // Store port.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // Walk decode.
  logic [ENTRY_W-1:0] rd_entry;
  logic [PPN_W-1:0]   rel;
  logic               rel_in_store;
  logic [PAGE_W-1:0]  rel_page;
  logic [NF_W:0]      nf_plus1, nf_plus2;
  logic [IDX_W-1:0]   idx2, idx1, idx0;
  logic               in_fire, out_fire, out_free;

  sv39pm_table_ram #(
    .DEPTH  (STORE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign idx2 = vpn[3*IDX_W-1:2*IDX_W];
  assign idx1 = vpn[2*IDX_W-1:IDX_W];
  assign idx0 = vpn[IDX_W-1:0];

  assign in_fire  = req.valid && req.ready;
  assign out_fire = rsp.valid && rsp.ready;
  assign out_free = !out_valid || rsp.ready;

  assign rd_entry     = ram_rdata;
  assign rel          = rd_entry[ENTRY_W-1:PERM_W] - table_base_ppn;
  assign rel_in_store = rel < PPN_W'(TABLE_PAGES);
  assign rel_page     = rel[PAGE_W-1:0];
  assign nf_plus1     = {1'b0, next_free} + (NF_W+1)'(1);
  assign nf_plus2     = {1'b0, next_free} + (NF_W+1)'(2);

  assign req.ready = (state == S_IDLE);

  // Walk sequencer: plan with up to two reads, then commit with up to three writes.
  always_comb begin
    state_next      = state;
    next_free_next  = next_free;
    l1_page_next    = l1_page;
    l0_page_next    = l0_page;
    need_next       = need;
    err_next        = err;
    ram_we          = 1'b0;
    ram_addr        = slot('0, req.virt_page_number[3*IDX_W-1:2*IDX_W]);
    ram_wdata       = '0;
    case (state)
      S_CLEAR: begin
        // Zero one entry a cycle; the last entry ends the pass.
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // Root lookup issued straight from the request word.
        need_next       = 2'd0;
        err_next        = 1'b0;
        if (in_fire) begin
          state_next = S_RD2;
        end
      end
      S_RD2: begin
        if (!rd_entry[0]) begin
          // Level 1 and level 0 tables both missing.
          l1_page_next = next_free[PAGE_W-1:0];
          l0_page_next = nf_plus1[PAGE_W-1:0];
          need_next    = 2'd2;
          if (nf_plus2 > (NF_W+1)'(TABLE_PAGES)) begin
            err_next   = 1'b1;
            need_next  = 2'd0;
            state_next = S_OUT;
          end else begin
            next_free_next = nf_plus2[NF_W-1:0];
            state_next     = S_W2;
          end
        end else if (!rel_in_store) begin
          err_next   = 1'b1;
          state_next = S_OUT;
        end else begin
          l1_page_next    = rel_page;
          ram_addr        = slot(rel_page, idx1);
          state_next      = S_RD1;
        end
      end
      S_RD1: begin
        if (!rd_entry[0]) begin
          l0_page_next = next_free[PAGE_W-1:0];
          need_next    = 2'd1;
          if (nf_plus1 > (NF_W+1)'(TABLE_PAGES)) begin
            err_next   = 1'b1;
            need_next  = 2'd0;
            state_next = S_OUT;
          end else begin
            next_free_next = nf_plus1[NF_W-1:0];
            state_next     = S_W1;
          end
        end else if (!rel_in_store) begin
          err_next   = 1'b1;
          state_next = S_OUT;
        end else begin
          l0_page_next = rel_page;
          state_next   = S_W0;
        end
      end
      S_W2: begin
        ram_we     = 1'b1;
        ram_addr   = slot('0, idx2);
        ram_wdata  = pointer_entry(table_base_ppn + PPN_W'(l1_page));
        state_next = S_W1;
      end
      S_W1: begin
        ram_we     = 1'b1;
        ram_addr   = slot(l1_page, idx1);
        ram_wdata  = pointer_entry(table_base_ppn + PPN_W'(l0_page));
        state_next = S_W0;
      end
      S_W0: begin
        ram_we     = 1'b1;
        ram_addr   = slot(l0_page, idx0);
        ram_wdata  = {ppn, perm};
        state_next = S_OUT;
      end
      S_OUT: begin
        // Hold until the result register is free.
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      next_free      <= NF_W'(1);
      out_valid      <= 1'b0;
      table_base_ppn <= '0;
      err            <= 1'b0;
      need           <= 2'd0;
    end else begin
      state      <= state_next;
      next_free  <= next_free_next;
      err        <= err_next;
      need       <= need_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_wr_en) begin
        table_base_ppn <= cfg_wr_data;
      end
      // Load a finished word, drop one that has been taken.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    l1_page <= l1_page_next;
    l0_page <= l0_page_next;
    if (in_fire) begin
      vpn  <= req.virt_page_number;
      ppn  <= req.phys_page_number;
      perm <= req.perm;
      last <= req.last_page;
    end
    if (state == S_OUT && out_free) begin
      out_status <= err ? STATUS_ERROR : STATUS_OK;
      out_leaf   <= err ? '0 : {ppn, perm};
      out_added  <= err ? 2'd0 : need;
      out_done   <= last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.leaf_entry   = out_leaf;
  assign rsp.tables_added = out_added;
  assign rsp.request_done = out_done;

  // The pool never hands out more pages than the store holds.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NF_W'(TABLE_PAGES))
    else $error("table pool fill mark beyond store");

  // Every write outside the clearing pass lands in a page already handed out.
  a_write_allocated: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != S_CLEAR) |-> (NF_W'(ram_addr[ADDR_W-1:IDX_W]) < next_free))
    else $error("store write to a page not yet allocated");

  // A failed page reports no leaf and no allocation.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_ERROR) |-> (rsp.leaf_entry == '0 &&
                                                   rsp.tables_added == 2'd0))
    else $error("error word carries a mapping");

  // An error never touches the store.
  a_error_no_write: assert property (@(posedge clk) disable iff (rst)
    (err && state == S_OUT) |-> $past(!ram_we))
    else $error("store written for a failed page");

endmodule
